[sv/bmb_pkg.sv]
// Shared types and constants for the band meter ballistics unit.
// Used by bmb_ctl, bmb_dp and band_meter_ballistics_unit; no dependencies.
package bmb_pkg;

   // Default sizing handed to the top-level parameters.
   localparam int BAND_COUNT_DEF = 64;
   localparam int LEVEL_BITS_DEF = 11;

   // Item opcodes.
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_PEAK_HOLD_FRAMES = 1'b0;
   localparam logic CSR_METER_HEIGHT     = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [7:0] PEAK_HOLD_RESET    = 8'd20;
   localparam logic [9:0] METER_HEIGHT_RESET = 10'd256;

   // Decay factors after reset or clear, Q0.32.
   localparam logic [31:0] HOLD_DECAY_INIT = 32'd4294838447;
   localparam logic [31:0] PEAK_DECAY_INIT = 32'd4294966008;

   // Input word.
   typedef struct packed {
      logic        opcode;
      logic [5:0]  band_index;
      logic [23:0] magnitude;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [10:0] bar_level;
      logic [10:0] peak_level;
   } rsp_type;

   // Controller sequence; each state is also the datapath step it commands.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_NORM,
      ST_LOG,
      ST_DB,
      ST_LV,
      ST_BAR,
      ST_DIV,
      ST_FIX,
      ST_HOLD,
      ST_HSQ,
      ST_PEAK,
      ST_PSQ,
      ST_WRITE,
      ST_DONE
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      ctl_state_type step;
      logic          accept;
      logic          load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip;
   } dp_status_type;

endpackage

[sv/bmb_ctl.sv]
// Controller state machine of the band meter ballistics unit.
// Depends on bmb_pkg; sequences bmb_dp and owns both handshakes.
module bmb_ctl
   import bmb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   logic [3:0]    iter_ff, iter_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_READ;
         ST_READ:  state_in = status.skip ? ST_WRITE : ST_NORM;
         ST_NORM:  state_in = ST_LOG;
         ST_LOG:   if (iter_ff == 4'd15) state_in = ST_DB;
         ST_DB:    state_in = ST_LV;
         ST_LV:    state_in = ST_BAR;
         ST_BAR:   state_in = ST_DIV;
         ST_DIV:   state_in = ST_FIX;
         ST_FIX:   state_in = ST_HOLD;
         ST_HOLD:  state_in = ST_HSQ;
         ST_HSQ:   state_in = ST_PEAK;
         ST_PEAK:  state_in = ST_PSQ;
         ST_PSQ:   state_in = ST_WRITE;
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs and the squaring-loop counter.
   always_comb begin
      cmd.step     = state_ff;
      cmd.accept   = accept;
      cmd.load_rsp = (state_ff == ST_DONE) && out_free;
      req_stall    = (state_ff != ST_IDLE);
      iter_in      = (state_ff == ST_LOG) ? iter_ff + 4'd1 : 4'd0;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_READ))
      else $error("accepted word did not start a band read");
   a_log_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOG && iter_ff == 4'd15) |=> (state_ff == ST_DB))
      else $error("log loop did not end after sixteen steps");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !out_free) |=> (state_ff == ST_DONE))
      else $error("result dropped while output busy");
`endif

endmodule

[sv/bmb_dp.sv]
// Datapath of the band meter ballistics unit: band state memories, shared
// multiplier, log, IEC scale and decay arithmetic. Depends on bmb_pkg.
module bmb_dp
   import bmb_pkg::*;
#(
   parameter int BAND_COUNT = BAND_COUNT_DEF,
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  req_type       req_data,
   output rsp_type       rsp_data,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [9:0]    csr_wdata
);

   localparam int IDX_BITS  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
   localparam int PEAK_BITS = LEVEL_BITS + 16;
   localparam int LEVEL_MAX = (1 << LEVEL_BITS) - 1;

   localparam logic [31:0] DB_PER_OCTAVE = 32'd394566;
   localparam logic [31:0] RECIP_4000    = 32'd1073741;
   localparam logic signed [24:0] DB_OFFSET = 25'sd8680452;
   localparam logic signed [24:0] DB_LO     = -25'sd4587520;
   localparam logic signed [24:0] DB_HI     = 25'sd262144;

   // Latched item and configuration.
   req_type     req_ff;
   logic [7:0]  hold_frames_ff;
   logic [9:0]  height_ff;

   // Band state memories and valid bits.
   logic [LEVEL_BITS-1:0] hl_mem [BAND_COUNT];
   logic [31:0]           hd_mem [BAND_COUNT];
   logic [PEAK_BITS-1:0]  pv_mem [BAND_COUNT];
   logic [31:0]           pd_mem [BAND_COUNT];
   logic [8:0]            pw_mem [BAND_COUNT];
   logic [BAND_COUNT-1:0] vld_ff;

   logic [LEVEL_BITS-1:0] hl_rd_ff;
   logic [31:0]           hd_rd_ff;
   logic [PEAK_BITS-1:0]  pv_rd_ff;
   logic [31:0]           pd_rd_ff;
   logic [8:0]            pw_rd_ff;

   // Working registers.
   logic [LEVEL_BITS-1:0] hl_ff;
   logic [31:0]           hd_ff;
   logic [PEAK_BITS-1:0]  pv_ff;
   logic [31:0]           pd_ff;
   logic [8:0]            pw_ff;
   logic [31:0]           x_ff;
   logic [4:0]            exp_ff;
   logic [15:0]           frac_ff;
   logic                  zero_ff;
   logic signed [24:0]    db_ff;
   logic [28:0]           lv_ff;
   logic [22:0]           q_ff;
   logic [11:0]           est_ff;
   logic [LEVEL_BITS-1:0] y_ff;
   logic [LEVEL_BITS-1:0] hdec_ff;
   logic [LEVEL_BITS-1:0] nh_ff;
   logic [31:0]           nhd_ff;
   logic [LEVEL_BITS-1:0] yy_ff;
   logic [PEAK_BITS-1:0]  pdec_ff;
   logic [8:0]            nw_ff;
   logic [PEAK_BITS-1:0]  npv_ff;
   logic [31:0]           npd_ff;
   rsp_type               res_ff;
   rsp_type               rsp_ff;

   logic [IDX_BITS-1:0] idx;
   logic                in_range;
   logic [4:0]          lead;
   logic [31:0]         mul_a, mul_b;
   logic [63:0]         prod;
   logic [32:0]         sq_t;
   logic signed [24:0]  db_raw;
   logic [6:0]          slope;
   logic [10:0]         off;
   logic signed [24:0]  dk;
   logic [22:0]         est_x;
   logic [22:0]         rem;
   logic [11:0]         bar;
   logic [PEAK_BITS-1:0] yy_sh;
   logic                p_lt;

   assign idx      = IDX_BITS'(req_ff.band_index);
   assign in_range = (32'(req_ff.band_index) < BAND_COUNT);
   assign status.skip = (req_ff.opcode == OP_CLEAR) || !in_range;
   assign rsp_data = rsp_ff;

   // Leading one of the magnitude.
   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (req_ff.magnitude[i]) lead = 5'(i);
      end
   end

   // IEC segment for the current dB value.
   always_comb begin
      if (db_ff < -25'sd3932160) begin
         slope = 7'd10;  off = 11'd0;    dk = db_ff + 25'sd4587520;
      end else if (db_ff < -25'sd3276800) begin
         slope = 7'd20;  off = 11'd100;  dk = db_ff + 25'sd3932160;
      end else if (db_ff < -25'sd2621440) begin
         slope = 7'd30;  off = 11'd300;  dk = db_ff + 25'sd3276800;
      end else if (db_ff < -25'sd1966080) begin
         slope = 7'd60;  off = 11'd600;  dk = db_ff + 25'sd2621440;
      end else if (db_ff < -25'sd1310720) begin
         slope = 7'd80;  off = 11'd1200; dk = db_ff + 25'sd1966080;
      end else begin
         slope = 7'd100; off = 11'd2000; dk = db_ff + 25'sd1310720;
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      case (cmd.step)
         ST_LOG:  begin mul_a = x_ff;                      mul_b = x_ff;             end
         ST_DB:   begin mul_a = 32'({exp_ff, frac_ff});    mul_b = DB_PER_OCTAVE;    end
         ST_LV:   begin mul_a = 32'(slope);                mul_b = 32'(dk[20:0]);    end
         ST_BAR:  begin mul_a = 32'(lv_ff);                mul_b = 32'(height_ff);   end
         ST_DIV:  begin mul_a = 32'(q_ff);                 mul_b = RECIP_4000;       end
         ST_HOLD: begin mul_a = 32'(hl_ff);                mul_b = hd_ff;            end
         ST_HSQ:  begin mul_a = hd_ff;                     mul_b = hd_ff;            end
         ST_PEAK: begin mul_a = 32'(pv_ff);                mul_b = pd_ff;            end
         ST_PSQ:  begin mul_a = pd_ff;                     mul_b = pd_ff;            end
         default: begin mul_a = 32'd0;                     mul_b = 32'd0;            end
      endcase
   end

   assign prod = {32'd0, mul_a} * {32'd0, mul_b};

   // Helpers that follow the product.
   always_comb begin
      sq_t   = prod[63:31];
      db_raw = $signed({1'b0, prod[39:16]}) - DB_OFFSET;
      est_x  = 23'(32'(est_ff) * 32'd4000);
      rem    = q_ff - est_x;
      bar    = (rem >= 23'd4000) ? est_ff + 12'd1 : est_ff;
      yy_sh  = {yy_ff, 16'd0};
      p_lt   = (pv_ff < yy_sh);
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_frames_ff <= PEAK_HOLD_RESET;
         height_ff      <= METER_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PEAK_HOLD_FRAMES: hold_frames_ff <= csr_wdata[7:0];
            CSR_METER_HEIGHT:     height_ff      <= csr_wdata;
            default:              ;
         endcase
      end
   end

   // Valid bits: a band not valid reads as its reset state.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.step == ST_WRITE && in_range) begin
         vld_ff[idx] <= (req_ff.opcode != OP_CLEAR);
      end
   end

   // Band state memories, registered read.
   always_ff @(posedge clock) begin
      if (cmd.step == ST_WRITE && in_range && req_ff.opcode != OP_CLEAR) begin
         hl_mem[idx] <= nh_ff;
         hd_mem[idx] <= nhd_ff;
         pv_mem[idx] <= npv_ff;
         pd_mem[idx] <= npd_ff;
         pw_mem[idx] <= nw_ff;
      end
      hl_rd_ff <= hl_mem[idx];
      hd_rd_ff <= hd_mem[idx];
      pv_rd_ff <= pv_mem[idx];
      pd_rd_ff <= pd_mem[idx];
      pw_rd_ff <= pw_mem[idx];
   end

   // Arithmetic steps.
   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_data;
      if (cmd.load_rsp) rsp_ff <= res_ff;
      case (cmd.step)
         // Fetch band state and normalize the magnitude.
         ST_NORM: begin
            if (vld_ff[idx]) begin
               hl_ff <= hl_rd_ff;
               hd_ff <= hd_rd_ff;
               pv_ff <= pv_rd_ff;
               pd_ff <= pd_rd_ff;
               pw_ff <= pw_rd_ff;
            end else begin
               hl_ff <= '0;
               hd_ff <= HOLD_DECAY_INIT;
               pv_ff <= '0;
               pd_ff <= PEAK_DECAY_INIT;
               pw_ff <= '0;
            end
            x_ff    <= 32'(req_ff.magnitude) << (5'd31 - lead);
            exp_ff  <= lead;
            frac_ff <= 16'd0;
            zero_ff <= (req_ff.magnitude == 24'd0);
         end
         // One fraction bit of log2 per squaring.
         ST_LOG: begin
            frac_ff <= {frac_ff[14:0], sq_t[32]};
            x_ff    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
         end
         // Scale log2 to dB and clamp.
         ST_DB: begin
            if (zero_ff || db_raw < DB_LO) begin
               db_ff <= DB_LO;
            end else if (db_raw > DB_HI) begin
               db_ff <= DB_HI;
            end else begin
               db_ff <= db_raw;
            end
         end
         // IEC level times 4000, Q16.
         ST_LV:  lv_ff  <= prod[28:0] + 29'({off, 16'd0});
         ST_BAR: q_ff   <= prod[38:16];
         ST_DIV: est_ff <= prod[43:32];
         // Correct the quotient and saturate.
         ST_FIX: begin
            if (32'(bar) > LEVEL_MAX) begin
               y_ff <= LEVEL_BITS'(LEVEL_MAX);
            end else begin
               y_ff <= LEVEL_BITS'(bar);
            end
         end
         ST_HOLD: hdec_ff <= prod[LEVEL_BITS+31:32];
         // Falling bar decision.
         ST_HSQ: begin
            if (hl_ff < y_ff) begin
               nh_ff  <= y_ff;
               nhd_ff <= HOLD_DECAY_INIT;
               yy_ff  <= y_ff;
            end else if (hdec_ff < y_ff) begin
               nh_ff  <= y_ff;
               nhd_ff <= hd_ff;
               yy_ff  <= y_ff;
            end else begin
               nh_ff  <= hdec_ff;
               nhd_ff <= prod[63:32];
               yy_ff  <= hdec_ff;
            end
         end
         // Peak wait count and decayed peak.
         ST_PEAK: begin
            pdec_ff <= prod[PEAK_BITS+31:32];
            if (p_lt) begin
               nw_ff <= 9'd0;
            end else if (pw_ff < 9'd511) begin
               nw_ff <= pw_ff + 9'd1;
            end else begin
               nw_ff <= pw_ff;
            end
         end
         // Peak decision.
         ST_PSQ: begin
            if (p_lt) begin
               npv_ff <= yy_sh;
               npd_ff <= PEAK_DECAY_INIT;
            end else if (nw_ff > {1'b0, hold_frames_ff}) begin
               npv_ff <= pdec_ff;
               npd_ff <= prod[63:32];
            end else begin
               npv_ff <= pv_ff;
               npd_ff <= pd_ff;
            end
         end
         // Form the result word.
         ST_WRITE: begin
            if (status.skip) begin
               res_ff <= '0;
            end else begin
               res_ff.bar_level  <= 11'(yy_ff);
               res_ff.peak_level <= 11'(npv_ff[PEAK_BITS-1:16]);
            end
         end
         default: ;
      endcase
   end

endmodule

[sv/band_meter_ballistics_unit.sv]
// Band meter ballistics unit: one word per band update or clear, one result.
// An update reads the band, normalizes, runs the bit-per-step log2 loop on the shared
// 32x32 multiplier, scales to dB and IEC level, forms the bar, decays and writes; a clear
// or a band out of range goes from the read straight to the write. A new word is taken
// only once the previous result has been loaded, which can wait on rsp_stall.
// Reset is synchronous and active high; it marks all bands at their reset
// state through per-band valid bits and restores the configuration registers.
module band_meter_ballistics_unit
   import bmb_pkg::*;
#(
   parameter int BAND_COUNT = BAND_COUNT_DEF,
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [9:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   bmb_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and band state.
   bmb_dp #(
      .BAND_COUNT (BAND_COUNT),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

[test/testbench.sv]
// Testbench for band_meter_ballistics_unit: drives update and clear words,
// predicts bar and peak levels per band, and checks every result word.
// Depends on bmb_pkg and the unit's RTL only.
module testbench;
   import bmb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BANDS = 64;
   localparam logic [10:0] LEVEL_SAT = 11'h7FF;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic       csr_index;
   logic [9:0] csr_wdata;

   band_meter_ballistics_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predicted band state and register copies.
   logic [10:0] bar_hold_q[NUM_BANDS];
   logic [31:0] bar_decay_q[NUM_BANDS];
   logic [26:0] peak_q[NUM_BANDS];
   logic [31:0] peak_decay_q[NUM_BANDS];
   logic [8:0]  peak_age_q[NUM_BANDS];
   logic [7:0]  hold_frames_q;
   logic [9:0]  height_q;

   rsp_type levels_due[$];
   int      failures;
   bit      quiet;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic void reset_band(int b);
      bar_hold_q[b]   = '0;
      bar_decay_q[b]  = HOLD_DECAY_INIT;
      peak_q[b]       = '0;
      peak_decay_q[b] = PEAK_DECAY_INIT;
      peak_age_q[b]   = '0;
   endfunction

   // Decibels in Q16 from a Q2.22 magnitude, clamped to -70..+4 dB.
   function automatic longint mag_db(logic [23:0] m);
      longint lo;
      longint hi;
      int     p;
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] l;
      longint db;
      lo = -70 * 65536;
      hi = 4 * 65536;
      if (m == 0) return lo;
      p = 23;
      while (m[p] == 1'b0) p--;
      x = 64'(m) << (31 - p);
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 31;
         frac = frac << 1;
         if (x >= 64'h1_0000_0000) begin
            frac = frac | 1;
            x = x >> 1;
         end
      end
      l = 64'(longint'(p) * 65536 + longint'(frac));
      db = longint'((l * 64'd394566) >> 16) - 22 * 394566;
      if (db < lo) db = lo;
      if (db > hi) db = hi;
      return db;
   endfunction

   // IEC scale times the meter height, saturated to the level width.
   function automatic logic [10:0] iec_level(longint db);
      longint k, slope, off, lv;
      logic [63:0] bar;
      if (db < -60 * 65536) begin k = 70; slope = 10; off = 0; end
      else if (db < -50 * 65536) begin k = 60; slope = 20; off = 100; end
      else if (db < -40 * 65536) begin k = 50; slope = 30; off = 300; end
      else if (db < -30 * 65536) begin k = 40; slope = 60; off = 600; end
      else if (db < -20 * 65536) begin k = 30; slope = 80; off = 1200; end
      else begin k = 20; slope = 100; off = 2000; end
      lv = slope * (db + k * 65536) + off * 65536;
      if (lv < 0) lv = 0;
      bar = (64'(lv) * 64'(height_q)) / (64'd4000 * 64'd65536);
      if (bar > 64'(LEVEL_SAT)) bar = 64'(LEVEL_SAT);
      return bar[10:0];
   endfunction

   // Advances one band's ballistics and returns the shown levels.
   function automatic rsp_type meter_step(req_type w);
      rsp_type     r;
      int          b;
      logic [10:0] y;
      logic [63:0] h;
      r = '0;
      b = w.band_index;
      if (w.opcode == OP_CLEAR) begin
         reset_band(b);
         return r;
      end
      y = iec_level(mag_db(w.magnitude));
      if (bar_hold_q[b] < y) begin
         bar_hold_q[b] = y;
         bar_decay_q[b] = HOLD_DECAY_INIT;
      end else begin
         h = (64'(bar_hold_q[b]) * 64'(bar_decay_q[b])) >> 32;
         if (h < 64'(y)) bar_hold_q[b] = y;
         else begin
            bar_hold_q[b] = h[10:0];
            bar_decay_q[b] = 32'((64'(bar_decay_q[b]) * 64'(bar_decay_q[b])) >> 32);
            y = h[10:0];
         end
      end
      if (peak_q[b] < {y, 16'h0}) begin
         peak_q[b] = {y, 16'h0};
         peak_age_q[b] = '0;
         peak_decay_q[b] = PEAK_DECAY_INIT;
      end else begin
         if (peak_age_q[b] < 9'd511) peak_age_q[b]++;
         if (peak_age_q[b] > 9'(hold_frames_q)) begin
            peak_q[b] = 27'((64'(peak_q[b]) * 64'(peak_decay_q[b])) >> 32);
            peak_decay_q[b] = 32'((64'(peak_decay_q[b]) * 64'(peak_decay_q[b])) >> 32);
         end
      end
      r.bar_level = y;
      r.peak_level = peak_q[b][26:16];
      return r;
   endfunction

   // Sends one word with an optional idle burst ahead of it.
   task automatic send_word(logic op, logic [5:0] band, logic [23:0] mag);
      req_type w;
      if (!quiet && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(7, 1)) @(posedge clock);
      end
      w.opcode = op;
      w.band_index = band;
      w.magnitude = mag;
      req_data <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      levels_due.push_back(meter_step(w));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // One register write; the enable drops again before the next write.
   task automatic write_reg(logic idx, logic [9:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_PEAK_HOLD_FRAMES) hold_frames_q = value[7:0];
      else height_q = value;
      @(posedge clock);
   endtask

   // Random magnitude spread across the whole dB range.
   function automatic logic [23:0] rand_mag();
      case ($urandom_range(5))
         0: return 24'($urandom_range(15));
         1: return 24'hFFFFFF;
         default: return 24'($urandom) >> $urandom_range(23);
      endcase
   endfunction

   task automatic test_directed();
      send_word(OP_UPDATE, 6'd0, 24'd0);
      send_word(OP_UPDATE, 6'd0, 24'hFFFFFF);
      send_word(OP_UPDATE, 6'd0, 24'h400000);
      send_word(OP_UPDATE, 6'd0, 24'd1);
      send_word(OP_UPDATE, 6'd0, 24'd1);
      send_word(OP_UPDATE, 6'd63, 24'h200000);
      send_word(OP_UPDATE, 6'd63, 24'h000100);
      send_word(OP_UPDATE, 6'd63, 24'h000D00);
      send_word(OP_UPDATE, 6'd63, 24'h005000);
      send_word(OP_UPDATE, 6'd63, 24'h040000);
      send_word(OP_CLEAR, 6'd63, 24'hFFFFFF);
      send_word(OP_UPDATE, 6'd63, 24'd0);
      send_word(OP_CLEAR, 6'd0, 24'd0);
   endtask

   task automatic test_registers();
      drain_results();
      write_reg(CSR_METER_HEIGHT, 10'd1023);
      write_reg(CSR_PEAK_HOLD_FRAMES, 10'd0);
      send_word(OP_UPDATE, 6'd5, 24'hFFFFFF);
      for (int i = 0; i < 6; i++) send_word(OP_UPDATE, 6'd5, 24'd0);
      drain_results();
      write_reg(CSR_METER_HEIGHT, 10'd0);
      write_reg(CSR_PEAK_HOLD_FRAMES, 10'd255);
      send_word(OP_UPDATE, 6'd6, 24'hFFFFFF);
      send_word(OP_UPDATE, 6'd5, 24'h123456);
      drain_results();
      write_reg(CSR_METER_HEIGHT, 10'd1);
      send_word(OP_UPDATE, 6'd7, 24'hFFFFFF);
      drain_results();
   endtask

   // Bursts of frames on few bands so bars fall and peaks outlive the hold.
   task automatic test_random(int words);
      logic [5:0]  band;
      logic [23:0] mag;
      for (int i = 0; i < words; i++) begin
         if (i % 110 == 0) begin
            drain_results();
            write_reg(CSR_PEAK_HOLD_FRAMES, 10'($urandom_range(2) == 0 ? 255 :
                      $urandom_range(12)));
            write_reg(CSR_METER_HEIGHT, 10'($urandom_range(1023)));
         end
         if (i >= words - 60) quiet = 1'b1;
         band = 6'($urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(3));
         mag = ($urandom_range(2) == 0) ? rand_mag() : 24'd0;
         if ($urandom_range(30) == 0) send_word(OP_CLEAR, band, 24'($urandom));
         else send_word(OP_UPDATE, band, mag);
      end
   endtask

   // Receiver stalls in random bursts, none in the final stretch.
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (quiet) rsp_stall <= 1'b0;
         else if ($urandom_range(4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(7, 1)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result checker against the oldest predicted word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (levels_due.size() == 0) begin
            $error("unexpected result word bar_level=%0d peak_level=%0d",
                   rsp_data.bar_level, rsp_data.peak_level);
            failures++;
         end else begin
            rsp_type want;
            want = levels_due.pop_front();
            if (rsp_data.bar_level !== want.bar_level) begin
               $error("bar_level expected %0d actual %0d", want.bar_level, rsp_data.bar_level);
               failures++;
            end
            if (rsp_data.peak_level !== want.peak_level) begin
               $error("peak_level expected %0d actual %0d",
                      want.peak_level, rsp_data.peak_level);
               failures++;
            end
         end
      end
   end

   initial begin
      failures = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_PEAK_HOLD_FRAMES;
      csr_wdata = '0;
      hold_frames_q = PEAK_HOLD_RESET;
      height_q = METER_HEIGHT_RESET;
      for (int b = 0; b < NUM_BANDS; b++) reset_band(b);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_registers();
      test_random(550);
      drain_results();
      if (failures == 0 && levels_due.size() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #4ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

[band_meter_ballistics_unit.f]
sv/bmb_pkg.sv
sv/bmb_ctl.sv
sv/bmb_dp.sv
sv/band_meter_ballistics_unit.sv
test/testbench.sv
